[sv/reversible_deque_engine_top_assert.svh]
// assertion macros shared by the deque engine rtl
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef REVERSIBLE_DEQUE_ENGINE_TOP_ASSERT_SVH
`define REVERSIBLE_DEQUE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge outside reset
`define RDE_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: invariant violated");

// consequent holds in the same cycle as the antecedent
`define RDE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// consequent holds in the cycle after the antecedent
`define RDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`else

`define RDE_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define RDE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[sv/rde_pkg.sv]
// shared types for the reversible deque engine
// used by rde_outq and reversible_deque_engine_top
`default_nettype none

package rde_pkg;

    localparam int unsigned RES_VALUE_W = 16;

    // input command codes
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_DELETE  = 2'd2,
        CMD_DRAIN   = 2'd3
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [RES_VALUE_W-1:0] value;
        logic                   last;
        logic                   error;
        logic                   empty_list;
        logic                   overflow;
    } result_t;

endpackage

`default_nettype wire

[sv/rde_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rde_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/rde_outq.sv]
// two-entry result queue that decouples the drain sequencer from the consumer
// depends on rde_pkg and the assertion macro header
`default_nettype none
`include "reversible_deque_engine_top_assert.svh"

module rde_outq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rde_pkg::result_t push_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output rde_pkg::result_t      res_data,
    output logic [1:0]            level
);

    rde_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             pop;

    assign pop       = res_valid && res_ready;
    assign res_valid = (cnt_reg != 2'd0);
    assign res_data  = entry_reg[rd_ptr_reg];
    assign level     = cnt_reg;

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `RDE_ASSERT_IMPL(a_no_overrun, clk, rst_n, push, (cnt_reg != 2'd2) || pop)
    `RDE_ASSERT_ALWAYS(a_level_range, clk, rst_n, cnt_reg <= 2'd2)

endmodule

`default_nettype wire

[sv/reversible_deque_engine_top.sv]
// reversible deque engine: push, reverse and delete are accepted one beat per cycle while no drain runs
// a drain holds off commands until its final beat is issued (a single status result if empty or in error);
// results are read via the registered ram port, one per cycle while the result queue has room
// reset is asynchronous active low and clears pointers, count and flags at once
// store contents are not cleared; only written entries are ever read, so there is no clearing pass
`default_nettype none
`include "reversible_deque_engine_top_assert.svh"

module reversible_deque_engine_top #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned VALUE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] value,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [15:0]      value_res,
    output logic             last,
    output logic             error,
    output logic             empty_list,
    output logic             overflow
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // metadata of a result whose data arrives from the ram next cycle
    typedef struct packed {
        logic last;
        logic error;
        logic empty_list;
        logic overflow;
        logic from_ram;
    } pend_t;

    state_t             state_reg;
    state_t             state_next;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic               rev_reg;
    logic               rev_next;
    logic               err_reg;
    logic               err_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    pend_t              pend_reg;
    pend_t              pend_next;

    logic               accept;
    rde_pkg::cmd_t      cmd;
    logic               full;
    logic               err_upd;
    logic [PTR_W-1:0]   head_inc;
    logic [CNT_W-1:0]   drain_off;
    logic               last_elem;
    logic [CNT_W:0]     wsum;
    logic [CNT_W:0]     wwrap;
    logic [CNT_W:0]     rsum;
    logic [CNT_W:0]     rwrap;
    logic [31:0]        val_wide;
    logic [31:0]        rd_wide;
    logic               issue_ok;
    logic [2:0]         occ;
    logic               pop;
    logic [1:0]         q_level;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] rd_data;

    rde_pkg::result_t   q_in;
    rde_pkg::result_t   q_out;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign cmd       = rde_pkg::cmd_t'(command);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign head_inc  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);

    // physical tail address for a push
    assign wsum    = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign wwrap   = (wsum >= (CNT_W+1)'(DEPTH)) ? wsum - (CNT_W+1)'(DEPTH) : wsum;
    assign wr_addr = wwrap[PTR_W-1:0];

    // value narrowed or widened to the store width
    assign val_wide = 32'(value);
    assign wr_data  = val_wide[VALUE_BITS-1:0];

    // drain read address in logical order
    assign drain_off = rev_reg ? (count_reg - CNT_W'(1) - idx_reg) : idx_reg;
    assign last_elem = (idx_reg == count_reg - CNT_W'(1));
    assign rsum      = (CNT_W+1)'(head_reg) + (CNT_W+1)'(drain_off);
    assign rwrap     = (rsum >= (CNT_W+1)'(DEPTH)) ? rsum - (CNT_W+1)'(DEPTH) : rsum;
    assign rd_addr   = rwrap[PTR_W-1:0];

    // credit check: room in the queue for the beat issued now
    assign pop      = res_valid && res_ready;
    assign occ      = {1'b0, q_level} + {2'b00, pend_valid_reg};
    assign issue_ok = ((occ - {2'b00, pop}) <= 3'd1);

    // command decode and drain sequencing
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rev_next        = rev_reg;
        err_next        = err_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = 1'b0;
        pend_next       = pend_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        err_upd         = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        rde_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        rde_pkg::CMD_REVERSE:
                        begin
                            rev_next = ~rev_reg;
                        end
                        rde_pkg::CMD_DELETE:
                        begin
                            err_upd  = err_reg || (count_reg == '0);
                            err_next = err_upd;
                            if (!err_upd)
                            begin
                                if (!rev_reg)
                                begin
                                    head_next = head_inc;
                                end
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        rde_pkg::CMD_DRAIN:
                        begin
                            state_next = ST_DRAIN;
                            idx_next   = '0;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (issue_ok)
                begin
                    pend_valid_next     = 1'b1;
                    pend_next.overflow  = ovf_reg;
                    pend_next.error     = 1'b0;
                    pend_next.empty_list = 1'b0;
                    pend_next.from_ram  = 1'b0;
                    pend_next.last      = 1'b1;
                    if (err_reg)
                    begin
                        pend_next.error = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_next.empty_list = 1'b1;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        pend_next.from_ram = 1'b1;
                        pend_next.last     = last_elem;
                        idx_next           = idx_reg + CNT_W'(1);
                    end
                    // the final beat returns to idle and clears head, count, reverse and flags
                    if (pend_next.last)
                    begin
                        state_next = ST_IDLE;
                        head_next  = '0;
                        count_next = '0;
                        rev_next   = 1'b0;
                        err_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered pending beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            rev_reg        <= 1'b0;
            err_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            rev_reg        <= rev_next;
            err_reg        <= err_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

    // element store
    rde_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // join read data with its metadata
    assign rd_wide          = 32'(rd_data);
    assign q_in.value       = pend_reg.from_ram ? rd_wide[15:0] : 16'd0;
    assign q_in.last        = pend_reg.last;
    assign q_in.error       = pend_reg.error;
    assign q_in.empty_list  = pend_reg.empty_list;
    assign q_in.overflow    = pend_reg.overflow;

    rde_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pend_valid_reg),
        .push_data (q_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (q_out),
        .level     (q_level)
    );

    assign value_res  = q_out.value;
    assign last       = q_out.last;
    assign error      = q_out.error;
    assign empty_list = q_out.empty_list;
    assign overflow   = q_out.overflow;

    `RDE_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `RDE_ASSERT_IMPL(a_idx_in_range, clk, rst_n, (state_reg == ST_DRAIN) && !err_reg && (count_reg != '0), idx_reg < count_reg)
    `RDE_ASSERT_NEXT(a_drain_clears, clk, rst_n, (state_reg == ST_DRAIN) && pend_valid_next && pend_next.last, (state_reg == ST_IDLE) && (count_reg == '0) && !err_reg)
    `RDE_ASSERT_IMPL(a_no_rw_overlap, clk, rst_n, rd_en, !wr_en)

endmodule

`default_nettype wire
